/* src/qlru_pkg.sv */
// Shared types and constants for the query-aware LRU column cache.
package qlru_pkg;

  localparam int FIELD_W    = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_FIRST = 2'd2;

  localparam logic [4:0] BUDGET_RST     = 5'd16;
  localparam logic [6:0] ATTR_COUNT_RST = 7'd64;

  typedef struct packed {
    logic load;
    logic col_next;
    logic srch_start;
    logic srch_step;
    logic shift_start;
    logic shift_step;
    logic tail;
    logic append;
    logic evict;
    logic refuse;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic col_end;
    logic col_need;
    logic srch_done;
    logic hit;
    logic absent_ok;
    logic room;
    logic vic;
    logic shift_done;
    logic out_free;
  } sts_t;

endpackage

/* src/qlru_ctrl.sv */
// Sequencer: walks columns, then search, decide and shift phases per needed column.
module qlru_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  qlru_pkg::sts_t sts,
  output qlru_pkg::cmd_t cmd
);
  import qlru_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_COL   = 3'd1;
  localparam logic [2:0] ST_SRCH  = 3'd2;
  localparam logic [2:0] ST_DEC   = 3'd3;
  localparam logic [2:0] ST_SHIFT = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_COL;
        end
      end
      ST_COL: begin
        if (sts.col_end) begin
          if (sts.out_free) begin
            cmd.publish = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end else if (!sts.col_need) begin
          cmd.col_next = 1'b1;
        end else begin
          cmd.srch_start = 1'b1;
          state_nxt      = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (sts.srch_done) begin
          state_nxt = ST_DEC;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      ST_DEC: begin
        priority if (sts.hit) begin
          cmd.shift_start = 1'b1;
          state_nxt       = ST_SHIFT;
        end else if (!sts.absent_ok) begin
          cmd.col_next = 1'b1;
          state_nxt    = ST_COL;
        end else if (sts.room) begin
          cmd.append   = 1'b1;
          cmd.col_next = 1'b1;
          state_nxt    = ST_COL;
        end else if (sts.vic) begin
          cmd.evict       = 1'b1;
          cmd.shift_start = 1'b1;
          state_nxt       = ST_SHIFT;
        end else begin
          cmd.refuse   = 1'b1;
          cmd.col_next = 1'b1;
          state_nxt    = ST_COL;
        end
      end
      ST_SHIFT: begin
        if (sts.shift_done) begin
          cmd.tail     = 1'b1;
          cmd.col_next = 1'b1;
          state_nxt    = ST_COL;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* src/qlru_dpath.sv */
// Datapath: config registers, masks, recency list memory with search and shift.
module qlru_dpath #(
  parameter int SLOTS       = 16,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [qlru_pkg::FIELD_W-1:0]      in_needed,
  input  logic [qlru_pkg::FIELD_W-1:0]      in_cached,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [qlru_pkg::FIELD_W-1:0]      out_cand,
  output logic [qlru_pkg::FIELD_W-1:0]      out_evicted,
  input  logic                              cfg_we,
  input  logic [qlru_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qlru_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  qlru_pkg::cmd_t                    cmd,
  output qlru_pkg::sts_t                    sts
);
  import qlru_pkg::*;

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int EB_W  = (CNT_W > 5) ? CNT_W : 5;

  logic [4:0]         budget_r;
  logic [6:0]         attr_r;
  logic               skip_r;

  logic [FIELD_W-1:0] needed_r, needed_nxt;
  logic [FIELD_W-1:0] cached_r, cached_nxt;
  logic [FIELD_W-1:0] cand_r, cand_nxt;
  logic [FIELD_W-1:0] evict_r, evict_nxt;
  logic               absent_ok_r, absent_ok_nxt;
  logic [6:0]         col_r, col_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [CNT_W-1:0]   sidx_r, sidx_nxt;
  logic               cvld_r, cvld_nxt;
  logic [IDX_W-1:0]   cidx_r, cidx_nxt;
  logic               sdone_r, sdone_nxt;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic               vic_r, vic_nxt;
  logic [IDX_W-1:0]   vic_idx_r, vic_idx_nxt;
  logic [COL_W-1:0]   vic_col_r, vic_col_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_cand_r, out_cand_nxt;
  logic [FIELD_W-1:0] out_evict_r, out_evict_nxt;

  logic [COL_W-1:0]   mem [SLOTS];
  logic [COL_W-1:0]   rd_q_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic [COL_W-1:0]   mem_wd;

  logic [6:0]         lim;
  logic [FIELD_W-1:0] rng;
  logic [FIELD_W-1:0] new_cand;
  logic [FIELD_W-1:0] col_bit;
  logic [COL_W-1:0]   col_id;
  logic [EB_W-1:0]    eff_budget;
  logic               issue;
  logic               last_cmp;
  logic [IDX_W-1:0]   shift_pos;

  always_comb begin
    lim = (attr_r > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : attr_r;
    for (int i = 0; i < FIELD_W; i++) begin
      rng[i] = (7'(i) >= {6'd0, skip_r}) && (7'(i) < lim);
    end
    new_cand   = in_needed & ~in_cached & rng;
    col_bit    = FIELD_W'(1) << col_r[5:0];
    col_id     = COL_W'(col_r);
    eff_budget = (EB_W'(budget_r) > EB_W'(SLOTS)) ? EB_W'(SLOTS) : EB_W'(budget_r);
    issue      = ((cmd.srch_step && !sdone_r) || cmd.shift_step) && (sidx_r < used_r);
    rd_addr    = issue ? IDX_W'(sidx_r) : '0;
    last_cmp   = (CNT_W'(cidx_r) + CNT_W'(1)) == used_r;
    shift_pos  = hit_r ? hit_idx_r : vic_idx_r;
  end

  always_comb begin
    sts.col_end    = (col_r >= lim);
    sts.col_need   = needed_r[col_r[5:0]];
    sts.srch_done  = sdone_r;
    sts.hit        = hit_r;
    sts.absent_ok  = absent_ok_r;
    sts.room       = EB_W'(used_r) < eff_budget;
    sts.vic        = vic_r;
    sts.shift_done = !cvld_r && (sidx_r >= used_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    needed_nxt    = needed_r;
    cached_nxt    = cached_r;
    cand_nxt      = cand_r;
    evict_nxt     = evict_r;
    absent_ok_nxt = absent_ok_r;
    col_nxt       = col_r;
    used_nxt      = used_r;
    sidx_nxt      = sidx_r;
    cvld_nxt      = cvld_r;
    cidx_nxt      = cidx_r;
    sdone_nxt     = sdone_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    vic_nxt       = vic_r;
    vic_idx_nxt   = vic_idx_r;
    vic_col_nxt   = vic_col_r;
    out_valid_nxt = out_valid_r;
    out_cand_nxt  = out_cand_r;
    out_evict_nxt = out_evict_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = col_id;

    if (cmd.load) begin
      needed_nxt    = in_needed;
      cached_nxt    = in_cached;
      cand_nxt      = new_cand;
      evict_nxt     = '0;
      absent_ok_nxt = |new_cand;
      col_nxt       = {6'd0, skip_r};
    end
    if (cmd.col_next) begin
      col_nxt = col_r + 7'd1;
    end

    if (cmd.srch_start) begin
      sidx_nxt  = '0;
      cvld_nxt  = 1'b0;
      hit_nxt   = 1'b0;
      vic_nxt   = 1'b0;
      sdone_nxt = (used_r == '0);
    end
    if ((cmd.srch_step && !sdone_r) || cmd.shift_step) begin
      cvld_nxt = issue;
      if (issue) begin
        sidx_nxt = sidx_r + CNT_W'(1);
        cidx_nxt = IDX_W'(sidx_r);
      end
    end
    if (cmd.srch_step && !sdone_r && cvld_r) begin
      if (7'(rd_q_r) == col_r) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = cidx_r;
        sdone_nxt   = 1'b1;
      end else begin
        if (!vic_r && !needed_r[6'(rd_q_r)]) begin
          vic_nxt     = 1'b1;
          vic_idx_nxt = cidx_r;
          vic_col_nxt = rd_q_r;
        end
        if (last_cmp) begin
          sdone_nxt = 1'b1;
        end
      end
    end

    if (cmd.shift_start) begin
      sidx_nxt = CNT_W'(shift_pos) + CNT_W'(1);
      cvld_nxt = 1'b0;
    end
    if (cmd.evict) begin
      evict_nxt = evict_r | (FIELD_W'(1) << 6'(vic_col_r));
    end
    if (cmd.refuse) begin
      cand_nxt = cand_r & ~col_bit;
    end
    if (cmd.append) begin
      used_nxt = used_r + CNT_W'(1);
    end

    priority if (cmd.shift_step && cvld_r) begin
      mem_we = 1'b1;
      mem_wa = cidx_r - IDX_W'(1);
      mem_wd = rd_q_r;
    end else if (cmd.tail) begin
      mem_we = 1'b1;
      mem_wa = IDX_W'(used_r - CNT_W'(1));
    end else if (cmd.append) begin
      mem_we = 1'b1;
      mem_wa = IDX_W'(used_r);
    end else begin
      mem_we = 1'b0;
    end

    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
      out_cand_nxt  = cand_r;
      out_evict_nxt = evict_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r    <= BUDGET_RST;
      attr_r      <= ATTR_COUNT_RST;
      skip_r      <= 1'b0;
      needed_r    <= '0;
      cached_r    <= '0;
      cand_r      <= '0;
      evict_r     <= '0;
      absent_ok_r <= 1'b0;
      col_r       <= '0;
      used_r      <= '0;
      sidx_r      <= '0;
      cvld_r      <= 1'b0;
      sdone_r     <= 1'b0;
      hit_r       <= 1'b0;
      vic_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BUDGET:     budget_r <= cfg_wdata[4:0];
          CFG_ATTR_COUNT: attr_r   <= cfg_wdata;
          CFG_SKIP_FIRST: skip_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
      needed_r    <= needed_nxt;
      cached_r    <= cached_nxt;
      cand_r      <= cand_nxt;
      evict_r     <= evict_nxt;
      absent_ok_r <= absent_ok_nxt;
      col_r       <= col_nxt;
      used_r      <= used_nxt;
      sidx_r      <= sidx_nxt;
      cvld_r      <= cvld_nxt;
      sdone_r     <= sdone_nxt;
      hit_r       <= hit_nxt;
      vic_r       <= vic_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cidx_r      <= cidx_nxt;
    hit_idx_r   <= hit_idx_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_col_r   <= vic_col_nxt;
    out_cand_r  <= out_cand_nxt;
    out_evict_r <= out_evict_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_cand    = out_cand_r;
  assign out_evicted = out_evict_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(used_r) <= CNT_W'(SLOTS))
    else $error("list count beyond slot count");

  a_evict_unneeded: assert property (@(posedge clk) disable iff (!rst_n)
    (evict_r & needed_r) == '0)
    else $error("evicted a column the query needs");

  a_cand_subset: assert property (@(posedge clk) disable iff (!rst_n)
    (cand_r & ~(needed_r & ~cached_r)) == '0)
    else $error("candidate bit outside needed and uncached");

  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid_r || out_ready))
    else $error("result overwritten before transfer");

endmodule

/* src/query_aware_lru_column_cache.sv */
// Top level of the query-aware LRU column cache.
//
//   channel | group  | payload
//   --------+--------+----------------------------------------------
//   query   | in_    | tdata: needed_mask, cached_mask
//   result  | out_   | tdata: candidate_mask, evicted_mask
//   config  | cfg_   | index 0 budget, 1 attribute_count, 2 skip_first_column
//
// One item at a time. Each query scans its columns; for each needed column the list is
// searched, and when an entry moves, the entries behind it shift one place toward the head.
// The list memory, with one read and one write port, moves one entry per cycle.
// Synchronous active-low reset empties the list and loads register defaults.
// The result sits in an output register, so a stalled out_ side holds only a finished
// result while the next query is taken.
module query_aware_lru_column_cache #(
  parameter int SLOTS       = 16,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [2*qlru_pkg::FIELD_W-1:0]    in_tdata,   // needed_mask, cached_mask
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [2*qlru_pkg::FIELD_W-1:0]    out_tdata,  // candidate_mask, evicted_mask
  input  logic                              cfg_we,
  input  logic [qlru_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qlru_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import qlru_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [FIELD_W-1:0] out_cand;
  logic [FIELD_W-1:0] out_evicted;

  qlru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  qlru_dpath #(
    .SLOTS       (SLOTS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_needed   (in_tdata[FIELD_W-1:0]),
    .in_cached   (in_tdata[2*FIELD_W-1:FIELD_W]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_cand    (out_cand),
    .out_evicted (out_evicted),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .sts         (sts)
  );

  assign out_tdata = {out_evicted, out_cand};

endmodule

/* tb/testbench.sv */
// Stream testbench for the query-aware LRU column cache, checked against an in-bench model.
`timescale 1ns / 1ps

module testbench;
  import qlru_pkg::*;

  localparam int SLOTS = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    logic [FIELD_W-1:0] evicted_mask;
    logic [FIELD_W-1:0] candidate_mask;
  } cache_outcome_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [2*FIELD_W-1:0]  in_tdata;    // needed_mask, cached_mask
  logic                  out_tvalid;
  logic                  out_tready;
  logic [2*FIELD_W-1:0]  out_tdata;   // candidate_mask, evicted_mask
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  query_aware_lru_column_cache dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  logic [2*FIELD_W-1:0] pending_queries [$];
  cache_outcome_t       awaited_masks [$];
  cache_outcome_t       got_masks;
  cache_outcome_t       want_masks;
  int                   mismatch_count;
  logic                 in_taken;
  int                   send_gap;
  int                   recv_stall;
  logic                 no_idle;
  int                   col_span;

  // model of the LRU list and registers
  logic [5:0] lru_col [SLOTS];
  int         lru_used;
  logic [4:0] reg_budget;
  logic [6:0] reg_attr;
  logic       reg_skip;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int lru_find(input int col);
    for (int j = 0; j < lru_used; j++)
      if (lru_col[j] == col) return j;
    return -1;
  endfunction

  task automatic lru_to_end(input int pos);
    logic [5:0] c;
    c = lru_col[pos];
    for (int j = pos; j + 1 < lru_used; j++) lru_col[j] = lru_col[j+1];
    lru_col[lru_used-1] = c;
  endtask

  task automatic lru_remove(input int pos);
    for (int j = pos; j + 1 < lru_used; j++) lru_col[j] = lru_col[j+1];
    lru_used--;
  endtask

  task automatic lru_append(input int col);
    if (lru_used < SLOTS) begin
      lru_col[lru_used] = col[5:0];
      lru_used++;
    end
  endtask

  task automatic lru_apply_query(input logic [FIELD_W-1:0] need, input logic [FIELD_W-1:0] have,
                                 output cache_outcome_t res);
    int lim;
    int first;
    int cap;
    int p;
    int victim;
    res = '0;
    lim = (reg_attr > 64) ? 64 : reg_attr;
    first = reg_skip;
    cap = (reg_budget > SLOTS) ? SLOTS : reg_budget;
    for (int i = first; i < lim; i++)
      if (need[i] && !have[i]) res.candidate_mask[i] = 1'b1;
    if (res.candidate_mask == '0) begin
      for (int i = first; i < lim; i++) begin
        if (need[i] && have[i]) begin
          p = lru_find(i);
          if (p >= 0) lru_to_end(p);
        end
      end
    end else begin
      for (int i = first; i < lim; i++) begin
        if (need[i]) begin
          p = lru_find(i);
          if (p >= 0) begin
            lru_to_end(p);
          end else if (lru_used >= cap) begin
            victim = -1;
            for (int j = 0; j < lru_used && victim < 0; j++)
              if (!need[lru_col[j]]) victim = j;
            if (victim >= 0) begin
              res.evicted_mask[lru_col[victim]] = 1'b1;
              lru_remove(victim);
              lru_append(i);
            end else begin
              res.candidate_mask[i] = 1'b0;
            end
          end else begin
            lru_append(i);
          end
        end
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  function automatic logic [2*FIELD_W-1:0] make_query();
    logic [FIELD_W-1:0] need;
    logic [FIELD_W-1:0] have;
    logic [FIELD_W-1:0] noise;
    int kind;
    int n;
    need = '0;
    have = '0;
    kind = $urandom_range(0, 99);
    noise = {$urandom, $urandom};
    if (kind < 10) begin
      need = noise;
      have = {$urandom, $urandom};
    end else if (kind < 15) begin
      have = noise;
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) need[$urandom_range(0, col_span - 1)] = 1'b1;
      if (kind < 40) have = need | (noise & {$urandom, $urandom});
      else have = need & noise;
      if ($urandom_range(0, 3) == 0) have = have | ({$urandom, $urandom} & {$urandom, $urandom});
    end
    return {have, need};
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_taken) begin
        // hold until the transfer completes
      end else if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_queries.size() > 0) begin
        in_tdata <= pending_queries.pop_front();
        in_tvalid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (recv_stall > 0) begin
      out_tready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 99) < 15) recv_stall <= pick_gap();
    end
  end

  // monitor and model
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
    if (!rst_n) begin
      lru_used = 0;
      reg_budget = BUDGET_RST;
      reg_attr = ATTR_COUNT_RST;
      reg_skip = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_masks = out_tdata;
        if (awaited_masks.size() == 0) begin
          $error("result transfer with no query outstanding: %h", out_tdata);
          mismatch_count++;
        end else begin
          want_masks = awaited_masks.pop_front();
          if (got_masks.candidate_mask !== want_masks.candidate_mask) begin
            $error("candidate_mask expected %h actual %h",
                   want_masks.candidate_mask, got_masks.candidate_mask);
            mismatch_count++;
          end
          if (got_masks.evicted_mask !== want_masks.evicted_mask) begin
            $error("evicted_mask expected %h actual %h",
                   want_masks.evicted_mask, got_masks.evicted_mask);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        lru_apply_query(in_tdata[FIELD_W-1:0], in_tdata[2*FIELD_W-1:FIELD_W], want_masks);
        awaited_masks.push_back(want_masks);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BUDGET:     reg_budget = cfg_wdata[4:0];
          CFG_ATTR_COUNT: reg_attr = cfg_wdata[6:0];
          CFG_SKIP_FIRST: reg_skip = cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [4:0] b, input logic [6:0] a, input logic s);
    write_reg(CFG_BUDGET, {2'b00, b});
    write_reg(CFG_ATTR_COUNT, a);
    write_reg(CFG_SKIP_FIRST, {6'd0, s});
  endtask

  // waits until every query is sent and every result is back, then a short settle
  task automatic drain();
    while (pending_queries.size() > 0 || in_tvalid || awaited_masks.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_query(input logic [FIELD_W-1:0] need, input logic [FIELD_W-1:0] have);
    pending_queries.push_back({have, need});
  endtask

  logic [4:0] budget_pick [5];
  logic [6:0] attr_pick [5];

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_taken = 1'b0;
    send_gap = 0;
    recv_stall = 0;
    no_idle = 1'b0;
    col_span = 20;
    mismatch_count = 0;
    budget_pick = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd4};
    attr_pick = '{7'd127, 7'd64, 7'd1, 7'd33, 7'd64};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed, register defaults
    push_query('0, '0);
    push_query('1, '0);
    push_query('1, '1);
    push_query(64'h0000_FF00_0000_0000, '0);
    push_query(64'h8000_0000_0000_0000, '0);
    // needed and cached but absent from the list, alongside an uncached one
    push_query(64'h0004_0000_0000_0020, 64'h0004_0000_0000_0000);
    push_query(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    push_query(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    drain();

    // budget below the current fill
    set_config(5'd3, 7'd64, 1'b0);
    push_query(64'h0000_0000_00F0_0000, '0);
    push_query(64'h1000_0000_0000_0000, '0);
    drain();

    // victim test sees needed bits beyond the scanned columns
    set_config(5'd16, 7'd8, 1'b0);
    push_query(64'hFFFF_FFFF_FFFF_FF03, '0);
    push_query(64'h0000_0000_0000_00F0, '0);
    drain();

    set_config(5'd0, 7'd64, 1'b0);
    push_query(64'h0000_0000_0000_000F, '0);
    drain();

    set_config(5'd16, 7'd0, 1'b0);
    push_query('1, '0);
    drain();

    set_config(5'd16, 7'd1, 1'b1);
    push_query('1, '0);
    drain();

    write_reg(CFG_UNUSED_IDX, 7'h7F);
    set_config(5'd31, 7'd127, 1'b0);
    push_query('1, '0);
    push_query(64'h1, 64'h1);
    drain();

    // random phases
    for (int p = 0; p < 10; p++) begin
      no_idle = (p % 3 == 0);
      case ($urandom_range(0, 2))
        0: col_span = 8;
        1: col_span = 20;
        default: col_span = 64;
      endcase
      if (p < 5) set_config(budget_pick[p], attr_pick[p], p[0]);
      else set_config(5'($urandom_range(1, 16)), 7'($urandom_range(2, 64)),
                      1'($urandom_range(0, 1)));
      repeat (50) pending_queries.push_back(make_query());
      drain();
    end

    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && awaited_masks.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
